[rtl/core/shca_pkg.sv]
// types and constants shared by the strip hit cluster accumulator
package shca_pkg;

	localparam int unsigned STRIP_W    = 7;
	localparam int unsigned DSSD_W     = 3;
	localparam int unsigned TIME_W     = 48;
	localparam int unsigned FAST_W     = 32;
	localparam int unsigned EN_W       = 24;
	localparam int unsigned WIN_W      = 24;
	localparam int unsigned ESUM_W     = 32;
	localparam int unsigned SSUM_W     = 16;
	localparam int unsigned CNT_W      = 8;
	localparam int unsigned CENT_W     = 15;
	localparam int unsigned FRAC_W     = 8;
	localparam int unsigned DIVIDEND_W = SSUM_W + FRAC_W;
	localparam int unsigned DIV_STEPS  = DIVIDEND_W;
	localparam int unsigned DSTEP_W    = $clog2(DIV_STEPS);
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic                clear_first;
		logic                add;
		logic [DSSD_W-1:0]   dssd;
		logic                side;
		logic                high_energy;
		logic [STRIP_W-1:0]  strip;
		logic [TIME_W-1:0]   hit_time;
		logic [FAST_W-1:0]   fast_time;
		logic [EN_W-1:0]     energy;
	} hit_t;

	typedef struct packed {
		logic                adjacent;
		logic                good_time;
		logic [DSSD_W-1:0]   cluster_dssd;
		logic [ESUM_W-1:0]   energy_sum;
		logic [CENT_W-1:0]   strip_centroid;
		logic [STRIP_W-1:0]  strip_low;
		logic [STRIP_W-1:0]  strip_high;
		logic [TIME_W-1:0]   time_low;
		logic [TIME_W-1:0]   time_high;
		logic [FAST_W-1:0]   fast_low;
		logic [FAST_W-1:0]   fast_high;
		logic [CNT_W-1:0]    hit_count;
	} result_t;

	typedef struct packed {
		logic                valid;
		logic [DSSD_W-1:0]   dssd;
		logic                side;
		logic                high_energy;
		logic [ESUM_W-1:0]   energy_sum;
		logic [STRIP_W-1:0]  strip_low;
		logic [STRIP_W-1:0]  strip_high;
		logic [TIME_W-1:0]   time_low;
		logic [TIME_W-1:0]   time_high;
		logic [FAST_W-1:0]   fast_low;
		logic [FAST_W-1:0]   fast_high;
		logic [SSUM_W-1:0]   strip_sum;
		logic [CNT_W-1:0]    count;
	} cluster_t;

	localparam cluster_t CLUSTER_EMPTY = '0;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [CNT_W-1:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic [CENT_W-1:0] quotient;
	} div_stat_t;

	typedef enum logic {
		BK_IDLE,
		BK_DIV
	} back_state_t;

endpackage

[rtl/core/shca_div.sv]
// centroid divider: restoring division, one quotient bit per cycle, saturating
module shca_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shca_pkg::div_req_t   req,
	output shca_pkg::div_stat_t  stat
);

	logic [shca_pkg::DIVIDEND_W-1:0] quo_q;
	logic [shca_pkg::CNT_W-1:0]      rem_q;
	logic [shca_pkg::CNT_W-1:0]      dvs_q;
	logic                            zero_q;
	logic [shca_pkg::DSTEP_W-1:0]    step_q;
	logic                            busy_q;

	logic [shca_pkg::CNT_W:0]        trial;
	logic                            take;
	logic [shca_pkg::CNT_W:0]        diff;

	always_comb begin
		trial = {rem_q, quo_q[shca_pkg::DIVIDEND_W-1]};
		take  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == shca_pkg::DSTEP_W'(shca_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
			zero_q <= (req.divisor == '0);
		end else if (busy_q) begin
			quo_q <= {quo_q[shca_pkg::DIVIDEND_W-2:0], take};
			rem_q <= take ? diff[shca_pkg::CNT_W-1:0] : trial[shca_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		stat.busy = busy_q;
		if (zero_q) begin
			stat.quotient = '0;
		end else if (|quo_q[shca_pkg::DIVIDEND_W-1:shca_pkg::CENT_W]) begin
			stat.quotient = '1;
		end else begin
			stat.quotient = quo_q[shca_pkg::CENT_W-1:0];
		end
	end

endmodule

[rtl/core/shca_front.sv]
// front end: takes hits, clamps strip and masks time, queues them for the back end
module shca_front #(
	parameter int unsigned STRIP_COUNT = 128,
	parameter int unsigned TIME_BITS   = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           hit_valid,
	output logic           hit_ready,
	input  shca_pkg::hit_t hit_data,
	output logic           q_valid,
	output shca_pkg::hit_t q_item,
	input  logic           q_pop
);

	localparam int unsigned TW = shca_pkg::TIME_W;
	localparam logic [TW-1:0] TMASK =
		(TIME_BITS >= TW) ? {TW{1'b1}} : TW'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [shca_pkg::STRIP_W-1:0] STRIP_MAX = shca_pkg::STRIP_W'(STRIP_COUNT - 1);

	shca_pkg::hit_t                  fifo_q [shca_pkg::QUEUE_DEPTH];
	logic [shca_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [shca_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [shca_pkg::QCNT_W-1:0]     cnt_q;

	shca_pkg::hit_t                  cooked;
	logic                            push;

	// strips beyond the detector width fold onto the last strip
	always_comb begin
		cooked          = hit_data;
		cooked.hit_time = hit_data.hit_time & TMASK;
		if (16'(hit_data.strip) >= 16'(STRIP_COUNT)) begin
			cooked.strip = STRIP_MAX;
		end
	end

	assign hit_ready = (cnt_q != shca_pkg::QCNT_W'(shca_pkg::QUEUE_DEPTH));
	assign push      = hit_valid && hit_ready;
	assign q_valid   = (cnt_q != '0);
	assign q_item    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cooked;
		end
	end

endmodule

[rtl/core/shca_back.sv]
// back end: cluster state, adjacency and time tests, merge, result register
module shca_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [shca_pkg::WIN_W-1:0]           cfg_wdata,
	input  logic                                 q_valid,
	input  shca_pkg::hit_t                       q_item,
	output logic                                 q_pop,
	output shca_pkg::div_req_t                   div_req,
	input  shca_pkg::div_stat_t                  div_stat,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output shca_pkg::result_t                    res_data
);

	localparam int unsigned TW = shca_pkg::TIME_W;

	shca_pkg::back_state_t         state_q;
	shca_pkg::back_state_t         state_nxt;
	shca_pkg::cluster_t            clus_q;
	logic [shca_pkg::WIN_W-1:0]    win_q;
	logic                          adj_q;
	logic                          good_q;
	logic                          res_valid_q;
	shca_pkg::result_t             res_data_q;

	shca_pkg::cluster_t            base;
	shca_pkg::cluster_t            nxt;
	logic                          adj;
	logic                          good;
	logic [TW:0]                   t_plus_win;
	logic [TW:0]                   high_plus_win;
	logic [shca_pkg::ESUM_W:0]     esum;
	logic [shca_pkg::SSUM_W:0]     ssum;
	logic                          slot_free;
	logic                          res_load;

	// state as seen by the tests: a clear empties it first
	always_comb begin
		base          = q_item.clear_first ? shca_pkg::CLUSTER_EMPTY : clus_q;
		t_plus_win    = {1'b0, q_item.hit_time} + (TW+1)'(win_q);
		high_plus_win = {1'b0, base.time_high} + (TW+1)'(win_q);
		if (!base.valid) begin
			adj  = 1'b1;
			good = 1'b1;
		end else begin
			adj  = (q_item.dssd == base.dssd) && (q_item.side == base.side)
				&& ({1'b0, q_item.strip} + 1'b1 >= {1'b0, base.strip_low})
				&& ({1'b0, q_item.strip} <= {1'b0, base.strip_high} + 1'b1);
			good = (t_plus_win >= {1'b0, base.time_low})
				&& ({1'b0, q_item.hit_time} <= high_plus_win);
		end
	end

	always_comb begin
		nxt  = base;
		esum = '0;
		ssum = '0;
		if (q_item.add) begin
			if (!base.valid) begin
				nxt.valid       = 1'b1;
				nxt.dssd        = q_item.dssd;
				nxt.side        = q_item.side;
				nxt.high_energy = q_item.high_energy;
				nxt.strip_low   = q_item.strip;
				nxt.strip_high  = q_item.strip;
				nxt.time_low    = q_item.hit_time;
				nxt.time_high   = q_item.hit_time;
				nxt.fast_low    = q_item.fast_time;
				nxt.fast_high   = q_item.fast_time;
			end
			esum = {1'b0, nxt.energy_sum} + (shca_pkg::ESUM_W+1)'(q_item.energy);
			nxt.energy_sum = esum[shca_pkg::ESUM_W] ? '1 : esum[shca_pkg::ESUM_W-1:0];
			if (q_item.strip < nxt.strip_low) begin
				nxt.strip_low = q_item.strip;
			end
			if (q_item.strip > nxt.strip_high) begin
				nxt.strip_high = q_item.strip;
			end
			if (q_item.hit_time < nxt.time_low) begin
				nxt.time_low = q_item.hit_time;
			end
			if (q_item.hit_time > nxt.time_high) begin
				nxt.time_high = q_item.hit_time;
			end
			if (q_item.fast_time < nxt.fast_low) begin
				nxt.fast_low = q_item.fast_time;
			end
			if (q_item.fast_time > nxt.fast_high) begin
				nxt.fast_high = q_item.fast_time;
			end
			ssum = {1'b0, nxt.strip_sum} + (shca_pkg::SSUM_W+1)'(q_item.strip);
			nxt.strip_sum = ssum[shca_pkg::SSUM_W] ? '1 : ssum[shca_pkg::SSUM_W-1:0];
			if (nxt.count != '1) begin
				nxt.count = nxt.count + 1'b1;
			end
		end
	end

	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			shca_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_nxt = shca_pkg::BK_DIV;
				end
			end
			shca_pkg::BK_DIV: begin
				if (!div_stat.busy && slot_free) begin
					state_nxt = shca_pkg::BK_IDLE;
				end
			end
			default: state_nxt = shca_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		res_load = 1'b0;
		case (state_q)
			shca_pkg::BK_IDLE: q_pop    = q_valid;
			shca_pkg::BK_DIV:  res_load = !div_stat.busy && slot_free;
			default: begin
				q_pop    = 1'b0;
				res_load = 1'b0;
			end
		endcase
	end

	// centroid in q7.8: strip sum scaled by 256 over the hit count
	always_comb begin
		div_req.start    = q_pop;
		div_req.dividend = {nxt.strip_sum, shca_pkg::FRAC_W'(0)};
		div_req.divisor  = nxt.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shca_pkg::BK_IDLE;
			clus_q      <= shca_pkg::CLUSTER_EMPTY;
			win_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (q_pop) begin
				clus_q <= nxt;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			adj_q  <= adj;
			good_q <= good;
		end
		if (res_load) begin
			res_data_q.adjacent       <= adj_q;
			res_data_q.good_time      <= good_q;
			res_data_q.cluster_dssd   <= clus_q.dssd;
			res_data_q.energy_sum     <= clus_q.energy_sum;
			res_data_q.strip_centroid <= div_stat.quotient;
			res_data_q.strip_low      <= clus_q.strip_low;
			res_data_q.strip_high     <= clus_q.strip_high;
			res_data_q.time_low       <= clus_q.time_low;
			res_data_q.time_high      <= clus_q.time_high;
			res_data_q.fast_low       <= clus_q.fast_low;
			res_data_q.fast_high      <= clus_q.fast_high;
			res_data_q.hit_count      <= clus_q.count;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

[rtl/core/strip_hit_cluster_accumulator.sv]
// Strip hit cluster accumulator. Each hit is tested against the cluster as it
// stood (adjacent strip on the same plane and side, time inside the window
// around the cluster time span) and optionally merged in; one result comes out
// per hit with both flags and the cluster summary, including the strip
// centroid in Q7.8. For each hit the back end tests and merges it, runs the
// centroid divider (one quotient bit per cycle) and loads the result
// register; it takes the next hit only after that load. A two-entry queue
// in front keeps taking hits until full while the back end works, and a
// finished result waits in its own register without holding up the next hit.
module strip_hit_cluster_accumulator #(
	parameter int unsigned STRIP_COUNT = 128,
	parameter int unsigned TIME_BITS   = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [shca_pkg::WIN_W-1:0]  cfg_wdata,
	input  logic                        hit_valid,
	output logic                        hit_ready,
	input  shca_pkg::hit_t              hit_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output shca_pkg::result_t           res_data
);

	logic                  q_valid;
	shca_pkg::hit_t        q_item;
	logic                  q_pop;
	shca_pkg::div_req_t    div_req;
	shca_pkg::div_stat_t   div_stat;

	shca_front #(
		.STRIP_COUNT (STRIP_COUNT),
		.TIME_BITS   (TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit_valid (hit_valid),
		.hit_ready (hit_ready),
		.hit_data  (hit_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	shca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	shca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.div_req   (div_req),
		.div_stat  (div_stat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule
